// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL of the timer pool.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge, off while reset is asserted.
`define PTP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("timer pool assertion failed");

// Condition that must never hold.
`define PTP_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  `PTP_ASSERT(lbl, clk, rst_n, !(expr))

`endif

// ===== rtl/ptp_pkg.sv =====
// Types and constants of the periodic timer pool.
package ptp_pkg;

  localparam int SLOTS       = 8;
  localparam int MAX_RESULTS = 8;
  localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int N_W         = $clog2(MAX_RESULTS + 1);

  localparam int CMD_W    = 3;
  localparam int SLOT_W   = 3;
  localparam int PERIOD_W = 31;
  localparam int TAG_W    = 16;
  localparam int CNT_W    = 32;
  localparam int STATUS_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_CREATE      = 3'd0,
    CMD_SET_PER     = 3'd1,
    CMD_SET_PER_TAG = 3'd2,
    CMD_FREE        = 3'd3,
    CMD_TICK        = 3'd4
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_NO_FREE  = 2'd1,
    ST_ZERO_PER = 2'd2,
    ST_BAD_SLOT = 2'd3
  } status_e;

  typedef enum logic {
    KIND_REPLY  = 1'b0,
    KIND_EXPIRY = 1'b1
  } kind_e;

  // token walking down the cell chain
  typedef struct packed {
    logic valid;
    logic tick;     // 1: tick walk, 0: create search
    logic claimed;  // create: a slot upstream was already taken
  } tok_t;

  // direct write bus, also carries create operands during a walk
  typedef struct packed {
    logic                en;
    cmd_e                op;
    logic [PERIOD_W-1:0] period;
    logic [TAG_W-1:0]    tag;
  } wr_t;

  // event from the cell that holds the token
  typedef struct packed {
    logic             hit;
    logic [TAG_W-1:0] tag;
  } ev_t;

endpackage

// ===== rtl/periodic_timer_pool.sv =====
// Periodic timer pool: a chain of SLOTS timer cells that a create search or a tick walks one
// slot per clock while the result side does not stall the chain. Set period, set period and
// tag, and free answer with one reply; create and tick walk the token through every cell in
// turn and then flush it out of the last. A create answers with one reply, a tick with one
// expiry item per expired slot in ascending slot order (at most MAX_RESULTS), the last item
// carrying tlast. A tick with no expiry and command codes 5 to 7 produce no item. A new item
// is taken once the walk is done and the output register is free.
module periodic_timer_pool (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // command[2:0], slot[5:3], period[36:6], tag[52:37], zero fill[55:53]
  input  logic [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], slot_out[4:2], tag_out[20:5], zero fill[23:21]
  output logic [23:0] m_axis_tdata,
  // kind
  output logic        m_axis_tuser,
  output logic        m_axis_tlast
);
  import ptp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_WALK  = 3'b010,
    S_FLUSH = 3'b100
  } state_e;

  state_e              state_q, state_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [N_W-1:0]      n_q, n_d;
  logic                tick_q, tick_d;
  logic [PERIOD_W-1:0] per_q, per_d;
  logic [TAG_W-1:0]    tagin_q, tagin_d;

  logic                pend_q, pend_d;
  logic [SLOT_W-1:0]   pend_slot_q, pend_slot_d;
  logic [TAG_W-1:0]    pend_tag_q, pend_tag_d;

  logic                out_valid_q, out_valid_d;
  kind_e               out_kind_q, out_kind_d;
  status_e             out_status_q, out_status_d;
  logic [SLOT_W-1:0]   out_slot_q, out_slot_d;
  logic [TAG_W-1:0]    out_tag_q, out_tag_d;
  logic                out_last_q, out_last_d;

  cmd_e                in_cmd;
  logic [SLOT_W-1:0]   in_slot;
  logic [PERIOD_W-1:0] in_period;
  logic [TAG_W-1:0]    in_tag;
  logic                in_acc;
  logic                out_free;
  logic                slot_ok;
  logic                wr_en;
  logic                step;
  logic                hit_acc;

  tok_t                tok_c [SLOTS+1];
  ev_t                 ev_c  [SLOTS];
  logic [SLOTS-1:0]    sel;
  logic [SLOTS:0]      tok_v;
  wr_t                 wr;
  logic                ev_hit;
  logic [TAG_W-1:0]    ev_tag;

  assign in_cmd    = cmd_e'(s_axis_tdata[2:0]);
  assign in_slot   = s_axis_tdata[5:3];
  assign in_period = s_axis_tdata[36:6];
  assign in_tag    = s_axis_tdata[52:37];

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && out_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign slot_ok       = 32'(in_slot) < SLOTS;

  assign wr.en     = wr_en;
  assign wr.op     = in_cmd;
  assign wr.period = (state_q == S_IDLE) ? in_period : per_q;
  assign wr.tag    = (state_q == S_IDLE) ? in_tag : tagin_q;

  assign tok_c[0].valid   = (state_q == S_WALK) && (idx_q == '0);
  assign tok_c[0].tick    = tick_q;
  assign tok_c[0].claimed = 1'b0;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    assign sel[i] = (32'(in_slot) == i);
    ptp_cell u_cell (
      .clk_i,
      .rst_ni,
      .step_i (step),
      .sel_i  (sel[i]),
      .wr_i   (wr),
      .tok_i  (tok_c[i]),
      .tok_o  (tok_c[i+1]),
      .ev_o   (ev_c[i])
    );
  end

  for (genvar i = 0; i <= SLOTS; i++) begin : g_tokv
    assign tok_v[i] = tok_c[i].valid;
  end

  // only the cell holding the token can raise a hit
  always_comb begin
    ev_hit = 1'b0;
    ev_tag = '0;
    for (int i = 0; i < SLOTS; i++) begin
      ev_hit = ev_hit | ev_c[i].hit;
      ev_tag = ev_tag | (ev_c[i].hit ? ev_c[i].tag : '0);
    end
  end

  assign hit_acc = ev_hit && (!tick_q || (n_q < N_W'(MAX_RESULTS)));

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    n_d          = n_q;
    tick_d       = tick_q;
    per_d        = per_q;
    tagin_d      = tagin_q;
    pend_d       = pend_q;
    pend_slot_d  = pend_slot_q;
    pend_tag_d   = pend_tag_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_kind_d   = out_kind_q;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    out_tag_d    = out_tag_q;
    out_last_d   = out_last_q;
    wr_en        = 1'b0;
    step         = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (in_cmd)
            CMD_CREATE: begin
              if (in_period == '0) begin
                out_valid_d  = 1'b1;
                out_kind_d   = KIND_REPLY;
                out_status_d = ST_ZERO_PER;
                out_slot_d   = '0;
                out_tag_d    = '0;
                out_last_d   = 1'b1;
              end else begin
                state_d = S_WALK;
                idx_d   = '0;
                n_d     = '0;
                tick_d  = 1'b0;
                per_d   = in_period;
                tagin_d = in_tag;
              end
            end
            CMD_SET_PER, CMD_SET_PER_TAG, CMD_FREE: begin
              wr_en        = slot_ok;
              out_valid_d  = 1'b1;
              out_kind_d   = KIND_REPLY;
              out_status_d = slot_ok ? ST_OK : ST_BAD_SLOT;
              out_slot_d   = in_slot;
              out_tag_d    = '0;
              out_last_d   = 1'b1;
            end
            CMD_TICK: begin
              state_d = S_WALK;
              idx_d   = '0;
              n_d     = '0;
              tick_d  = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_WALK: begin
        // hold the chain while a new hit would need the blocked output register
        step = !(hit_acc && pend_q && !out_free);
        if (step) begin
          if (hit_acc) begin
            if (pend_q) begin
              out_valid_d  = 1'b1;
              out_kind_d   = tick_q ? KIND_EXPIRY : KIND_REPLY;
              out_status_d = ST_OK;
              out_slot_d   = pend_slot_q;
              out_tag_d    = pend_tag_q;
              out_last_d   = 1'b0;
            end
            pend_d      = 1'b1;
            pend_slot_d = SLOT_W'(idx_q);
            pend_tag_d  = tick_q ? ev_tag : '0;
            n_d         = n_q + N_W'(1);
          end
          idx_d = idx_q + IDX_W'(1);
          if (idx_q == IDX_W'(SLOTS - 1)) begin
            idx_d   = '0;
            state_d = S_FLUSH;
          end
        end
      end
      S_FLUSH: begin
        // one more step moves the token out of the last cell
        step = 1'b1;
        if (out_free) begin
          if (pend_q) begin
            out_valid_d  = 1'b1;
            out_kind_d   = tick_q ? KIND_EXPIRY : KIND_REPLY;
            out_status_d = ST_OK;
            out_slot_d   = pend_slot_q;
            out_tag_d    = pend_tag_q;
            out_last_d   = 1'b1;
          end else if (!tick_q) begin
            out_valid_d  = 1'b1;
            out_kind_d   = KIND_REPLY;
            out_status_d = ST_NO_FREE;
            out_slot_d   = '0;
            out_tag_d    = '0;
            out_last_d   = 1'b1;
          end
          pend_d  = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      n_q         <= '0;
      tick_q      <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      n_q         <= n_d;
      tick_q      <= tick_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    per_q        <= per_d;
    tagin_q      <= tagin_d;
    pend_slot_q  <= pend_slot_d;
    pend_tag_q   <= pend_tag_d;
    out_kind_q   <= out_kind_d;
    out_status_q <= out_status_d;
    out_slot_q   <= out_slot_d;
    out_tag_q    <= out_tag_d;
    out_last_q   <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_tag_q, out_slot_q, out_status_q};
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

  `include "assert_macros.svh"

  `PTP_ASSERT(a_tok_onehot, clk_i, rst_ni, $onehot0(tok_v))
  `PTP_ASSERT(a_idle_no_pend, clk_i, rst_ni, (state_q == S_IDLE) |-> !pend_q)
  `PTP_ASSERT_NEVER(a_res_cap, clk_i, rst_ni, n_q > N_W'(MAX_RESULTS))
  `PTP_ASSERT(a_walk_tok, clk_i, rst_ni, (state_q == S_WALK) |-> tok_v[idx_q])

endmodule

// ===== rtl/ptp_cell.sv =====
// One timer slot: state, countdown and the token stage of the chain.
module ptp_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic          sel_i,
  input  ptp_pkg::wr_t  wr_i,
  input  ptp_pkg::tok_t tok_i,
  output ptp_pkg::tok_t tok_o,
  output ptp_pkg::ev_t  ev_o
);
  import ptp_pkg::*;

  logic                    active_q, active_d;
  logic [PERIOD_W-1:0]     reload_q, reload_d;
  logic signed [CNT_W-1:0] cnt_q, cnt_d, cnt_dec;
  logic [TAG_W-1:0]        tag_q, tag_d;
  tok_t                    tok_q, tok_d;
  logic                    expire;
  logic                    claim;

  assign cnt_dec = cnt_q - CNT_W'(1);
  assign expire  = tok_i.valid && tok_i.tick && active_q &&
                   (cnt_dec[CNT_W-1] || (cnt_dec == '0));
  assign claim   = tok_i.valid && !tok_i.tick && !active_q && !tok_i.claimed;

  always_comb begin
    active_d = active_q;
    reload_d = reload_q;
    cnt_d    = cnt_q;
    tag_d    = tag_q;
    tok_d    = tok_q;
    if (wr_i.en && sel_i) begin
      case (wr_i.op)
        CMD_SET_PER: begin
          reload_d = wr_i.period;
          cnt_d    = {1'b0, wr_i.period};
        end
        CMD_SET_PER_TAG: begin
          reload_d = wr_i.period;
          cnt_d    = {1'b0, wr_i.period};
          tag_d    = wr_i.tag;
          active_d = 1'b1;
        end
        CMD_FREE: active_d = 1'b0;
        default: ;
      endcase
    end
    if (step_i) begin
      tok_d = tok_i;
      if (tok_i.valid && tok_i.tick && active_q) begin
        cnt_d = expire ? {1'b0, reload_q} : cnt_dec;
      end
      if (claim) begin
        active_d      = 1'b1;
        reload_d      = wr_i.period;
        cnt_d         = {1'b0, wr_i.period};
        tag_d         = wr_i.tag;
        tok_d.claimed = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      tok_q    <= '0;
    end else begin
      active_q <= active_d;
      tok_q    <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    reload_q <= reload_d;
    cnt_q    <= cnt_d;
    tag_q    <= tag_d;
  end

  assign tok_o    = tok_q;
  assign ev_o.hit = expire || claim;
  assign ev_o.tag = tag_q;

endmodule
